/* rtl/core/pbv_pkg.sv */
// Shared types and constants of the settings record validator.
`default_nettype none
package pbv_pkg;

    localparam logic [31:0] CRC_POLY = 32'hEDB88320;
    localparam logic [31:0] CRC_ONES = 32'hFFFFFFFF;
    localparam logic [7:0]  ARP_MAX  = 8'd5;
    localparam logic [7:0]  WAVE_MAX = 8'd1;

    localparam logic [2:0] ST_OK          = 3'd0;
    localparam logic [2:0] ST_TOO_SHORT   = 3'd1;
    localparam logic [2:0] ST_BAD_MAGIC   = 3'd2;
    localparam logic [2:0] ST_BAD_VERSION = 3'd3;
    localparam logic [2:0] ST_BAD_SIZE    = 3'd4;
    localparam logic [2:0] ST_BAD_CRC     = 3'd5;

    localparam logic REG_MAGIC   = 1'b0;
    localparam logic REG_VERSION = 1'b1;

    localparam int ARP_OFS      = 9;
    localparam int WAVE_OFS     = 11;
    localparam int GEN_LO_OFS   = 16;
    localparam int GEN_HI_OFS   = 17;
    localparam int LOCK_LO_OFS  = 18;
    localparam int LOCK_HI_OFS  = 19;
    localparam int HEADER_BYTES = 8;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       buffer_end;
    } in_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [2:0]  arp_pattern;
        logic        pad_waveform;
        logic [15:0] generator_word;
        logic [15:0] lock_bits;
    } out_t;

    typedef struct packed {
        logic [31:0] expected_magic;
        logic [15:0] expected_version;
    } cfg_t;

endpackage
`default_nettype wire

/* rtl/core/pbv_crc_byte.sv */
// Reflected CRC-32 update over one byte, unrolled.
`default_nettype none
module pbv_crc_byte (
    input  wire logic [31:0] crc_in,
    input  wire logic [7:0]  data_in,
    output logic      [31:0] crc_out
);

    always_comb begin
        logic [31:0] c;
        c = crc_in ^ {24'd0, data_in};
        for (int k = 0; k < 8; k++) begin
            c = (c >> 1) ^ (c[0] ? pbv_pkg::CRC_POLY : 32'd0);
        end
        crc_out = c;
    end

endmodule
`default_nettype wire

/* rtl/core/pbv_record_check.sv */
// Record state, field capture and verdict for one byte per cycle while fire is high.
`default_nettype none
module pbv_record_check #(
    parameter int RECORD_BYTES = 256
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          fire,
    input  wire pbv_pkg::in_t  in_item,
    input  wire pbv_pkg::cfg_t cfg,
    output logic               res_valid,
    output pbv_pkg::out_t      res_item
);

    localparam int IDX_W = $clog2(RECORD_BYTES);
    localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(RECORD_BYTES - 1);
    localparam logic [IDX_W-1:0] CHECK_IDX = IDX_W'(RECORD_BYTES - 4);
    localparam logic [15:0]      REC_SIZE  = 16'(RECORD_BYTES);

    logic [IDX_W-1:0] idx_reg,    idx_next;
    logic [31:0]      crc_reg,    crc_next;
    logic             done_reg,   done_next;
    logic [63:0]      header_reg, header_next;
    logic [23:0]      stored_reg, stored_next;
    logic [7:0]       arp_reg,    arp_next;
    logic [7:0]       wave_reg,   wave_next;
    logic [15:0]      gen_reg,    gen_next;
    logic [15:0]      lock_reg,   lock_next;

    logic [31:0] crc_upd;
    logic [1:0]  check_pos;

    pbv_crc_byte u_crc (
        .crc_in  (crc_reg),
        .data_in (in_item.data_byte),
        .crc_out (crc_upd)
    );

    assign check_pos = 2'(idx_reg - CHECK_IDX);

    always_comb begin
        logic [7:0]  b;
        logic [31:0] stored_full;
        b           = in_item.data_byte;
        idx_next    = idx_reg;
        crc_next    = crc_reg;
        done_next   = done_reg;
        header_next = header_reg;
        stored_next = stored_reg;
        arp_next    = arp_reg;
        wave_next   = wave_reg;
        gen_next    = gen_reg;
        lock_next   = lock_reg;
        res_valid   = 1'b0;
        res_item    = '0;
        stored_full = {b, stored_reg};

        if (fire) begin
            if (done_reg) begin
                if (in_item.buffer_end) begin
                    idx_next  = '0;
                    crc_next  = pbv_pkg::CRC_ONES;
                    done_next = 1'b0;
                end
            end else begin
                if (idx_reg < IDX_W'(pbv_pkg::HEADER_BYTES)) begin
                    header_next[8*idx_reg[2:0] +: 8] = b;
                end
                if (idx_reg == IDX_W'(pbv_pkg::ARP_OFS)) begin
                    arp_next = b;
                end
                if (idx_reg == IDX_W'(pbv_pkg::WAVE_OFS)) begin
                    wave_next = b;
                end
                if (idx_reg == IDX_W'(pbv_pkg::GEN_LO_OFS)) begin
                    gen_next[7:0] = b;
                end
                if (idx_reg == IDX_W'(pbv_pkg::GEN_HI_OFS)) begin
                    gen_next[15:8] = b;
                end
                if (idx_reg == IDX_W'(pbv_pkg::LOCK_LO_OFS)) begin
                    lock_next[7:0] = b;
                end
                if (idx_reg == IDX_W'(pbv_pkg::LOCK_HI_OFS)) begin
                    lock_next[15:8] = b;
                end
                if (idx_reg < CHECK_IDX) begin
                    crc_next = crc_upd;
                end else if (idx_reg != LAST_IDX) begin
                    stored_next[8*check_pos +: 8] = b;
                end

                if (idx_reg == LAST_IDX) begin
                    res_valid = 1'b1;
                    if (header_reg[31:0] != cfg.expected_magic) begin
                        res_item.status = pbv_pkg::ST_BAD_MAGIC;
                    end else if (header_reg[47:32] != cfg.expected_version) begin
                        res_item.status = pbv_pkg::ST_BAD_VERSION;
                    end else if (header_reg[63:48] != REC_SIZE) begin
                        res_item.status = pbv_pkg::ST_BAD_SIZE;
                    end else if ((crc_reg ^ pbv_pkg::CRC_ONES) != stored_full) begin
                        res_item.status = pbv_pkg::ST_BAD_CRC;
                    end else begin
                        res_item.status         = pbv_pkg::ST_OK;
                        res_item.arp_pattern    =
                            (arp_reg > pbv_pkg::ARP_MAX) ? 3'd0 : arp_reg[2:0];
                        res_item.pad_waveform   =
                            (wave_reg > pbv_pkg::WAVE_MAX) ? 1'b0 : wave_reg[0];
                        res_item.generator_word = gen_reg;
                        res_item.lock_bits      = lock_reg;
                    end
                    if (in_item.buffer_end) begin
                        idx_next = '0;
                        crc_next = pbv_pkg::CRC_ONES;
                    end else begin
                        done_next = 1'b1;
                    end
                end else if (in_item.buffer_end) begin
                    res_valid       = 1'b1;
                    res_item.status = pbv_pkg::ST_TOO_SHORT;
                    idx_next        = '0;
                    crc_next        = pbv_pkg::CRC_ONES;
                end else begin
                    idx_next = idx_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg  <= '0;
            crc_reg  <= pbv_pkg::CRC_ONES;
            done_reg <= 1'b0;
        end else begin
            idx_reg  <= idx_next;
            crc_reg  <= crc_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        header_reg <= header_next;
        stored_reg <= stored_next;
        arp_reg    <= arp_next;
        wave_reg   <= wave_next;
        gen_reg    <= gen_next;
        lock_reg   <= lock_next;
    end

endmodule
`default_nettype wire

/* rtl/core/persist_blob_validator_core.sv */
// Top level of the settings record validator: request registers and APB port.
// Verdicts are registered in the output register, which drives m_valid.
// One byte per cycle while not stalled, set by the single unrolled CRC byte update.
// A full output register stalls the input register only while m_ready is low.
// Synchronous active-low reset clears handshake state and re-arms at offset 0;
// expected_magic resets to 0 and expected_version to 1.
`default_nettype none
module persist_blob_validator_core #(
    parameter int RECORD_BYTES = 256
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          s_valid,
    output logic               s_ready,
    input  wire pbv_pkg::in_t  s_payload,
    output logic               m_valid,
    input  wire logic          m_ready,
    output pbv_pkg::out_t      m_payload,
    input  wire logic          psel,
    input  wire logic          penable,
    input  wire logic          pwrite,
    input  wire logic [2:0]    paddr,
    input  wire logic [31:0]   pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    logic          in_valid_reg, in_valid_next;
    pbv_pkg::in_t  in_item_reg;
    logic          out_valid_reg, out_valid_next;
    pbv_pkg::out_t out_item_reg;
    pbv_pkg::cfg_t cfg_reg, cfg_next;

    logic          advance;
    logic          res_valid;
    pbv_pkg::out_t res_item;

    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;
    assign m_valid = out_valid_reg;
    assign m_payload = out_item_reg;
    assign pready = 1'b1;

    pbv_record_check #(
        .RECORD_BYTES (RECORD_BYTES)
    ) u_check (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .fire      (advance),
        .in_item   (in_item_reg),
        .cfg       (cfg_reg),
        .res_valid (res_valid),
        .res_item  (res_item)
    );

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_valid && s_ready) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end
        out_valid_next = out_valid_reg;
        if (advance && res_valid) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_comb begin
        cfg_next = cfg_reg;
        if (psel && penable && pwrite) begin
            case (paddr[2])
                pbv_pkg::REG_MAGIC: begin
                    cfg_next.expected_magic = pwdata;
                end
                pbv_pkg::REG_VERSION: begin
                    cfg_next.expected_version = pwdata[15:0];
                end
                default: begin
                    cfg_next = cfg_reg;
                end
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            pbv_pkg::REG_MAGIC: begin
                prdata = cfg_reg.expected_magic;
            end
            pbv_pkg::REG_VERSION: begin
                prdata = {16'd0, cfg_reg.expected_version};
            end
            default: begin
                prdata = 32'd0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            cfg_reg       <= '{expected_magic: 32'd0, expected_version: 16'd1};
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            cfg_reg       <= cfg_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_item_reg <= s_payload;
        end
        if (advance && res_valid) begin
            out_item_reg <= res_item;
        end
    end

endmodule
`default_nettype wire
